FILE: src/boxds_pkg.sv
// ----------------------------------------------------------------------------
// boxds_pkg
// Shared widths, register indexes, reset values, reciprocal table and the
// item type passed from the front end to the accumulate/divide back end.
// ----------------------------------------------------------------------------
package boxds_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_CHAN  = 2'd3;

  localparam int CFG_DATA_W = 13;
  localparam int DIM_W      = 13;   // source width / height register
  localparam int FAC_W      = 5;    // factor register
  localparam int CNT_W      = 12;   // pixel position counters
  localparam int BLK_W      = 4;    // position inside a block
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 16;
  localparam int NCHAN      = 3;

  localparam int MAX_OUT_COLS_DEF = 2048;
  localparam int MAX_FACTOR       = 16;
  localparam int MIN_FACTOR       = 2;
  localparam int SRC_MAX          = 4096;

  // Reset register values and the quotients that follow from them
  localparam int RST_SRC_WIDTH  = 64;
  localparam int RST_SRC_HEIGHT = 64;
  localparam int RST_FACTOR     = 2;
  localparam int RST_OUT_COLS   = RST_SRC_WIDTH / RST_FACTOR;
  localparam int RST_OUT_ROWS   = RST_SRC_HEIGHT / RST_FACTOR;

  // Iterative divider for the derived geometry
  localparam int DIV_STEPS = DIM_W;
  localparam int STEP_W    = 4;

  // sum / (f*f) == (sum * ceil(2^REC_SHIFT / (f*f))) >> REC_SHIFT for 16-bit sums
  localparam int REC_SHIFT = 25;
  localparam int REC_W     = 24;
  localparam int PROD_W    = SUM_W + REC_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [CNT_W-1:0]            col;    // output column
    logic                        fresh;  // first pixel of a block
    logic                        emit;   // last pixel of a block
    logic                        fend;   // last output of the frame
    logic [NCHAN-1:0][PIX_W-1:0] px;     // [0] first channel
  } item_t;

  function automatic logic [REC_W-1:0] recip(input logic [FAC_W-1:0] f);
    logic [REC_W-1:0] r;
    case (f)
      5'd2:    r = 24'd8388608;
      5'd3:    r = 24'd3728271;
      5'd4:    r = 24'd2097152;
      5'd5:    r = 24'd1342178;
      5'd6:    r = 24'd932068;
      5'd7:    r = 24'd684785;
      5'd8:    r = 24'd524288;
      5'd9:    r = 24'd414253;
      5'd10:   r = 24'd335545;
      5'd11:   r = 24'd277310;
      5'd12:   r = 24'd233017;
      5'd13:   r = 24'd198547;
      5'd14:   r = 24'd171197;
      5'd15:   r = 24'd149131;
      5'd16:   r = 24'd131072;
      default: r = 24'd8388608;
    endcase
    return r;
  endfunction

endpackage

FILE: src/boxds_front.sv
// ----------------------------------------------------------------------------
// boxds_front
// Register file, raster position counters and block classification. After a
// register write, a four-lane restoring divider re-derives the geometry.
// ----------------------------------------------------------------------------
module boxds_front #(
  parameter int MAX_OUT_COLS = boxds_pkg::MAX_OUT_COLS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [boxds_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [boxds_pkg::PIX_W-1:0]           chan_a_i,
  input  logic [boxds_pkg::PIX_W-1:0]           chan_b_i,
  input  logic [boxds_pkg::PIX_W-1:0]           chan_c_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output boxds_pkg::item_t                      item_o,
  output logic [boxds_pkg::REC_W-1:0]           recip_o
);

  localparam int DW = boxds_pkg::DIM_W;
  localparam int CW = boxds_pkg::CNT_W;
  localparam int FW = boxds_pkg::FAC_W;
  localparam int BW = boxds_pkg::BLK_W;
  localparam int NL = 4;  // lanes: width, height, column, row
  localparam logic [DW-1:0] KEEP_MAX = DW'(MAX_OUT_COLS);
  localparam logic [FW-1:0] F_MIN    = FW'(boxds_pkg::MIN_FACTOR);
  localparam logic [FW-1:0] F_MAX    = FW'(boxds_pkg::MAX_FACTOR);
  localparam logic [DW-1:0] S_MAX    = DW'(boxds_pkg::SRC_MAX);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV
  } state_e;

  state_e state_q, state_d;

  logic [DW-1:0] w_q, w_d, h_q, h_d;
  logic [FW-1:0] f_q, f_d;
  logic          tc_q, tc_d;

  logic [CW-1:0] col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [BW-1:0] cib_q, cib_d, rib_q, rib_d;
  logic [CW-1:0] ocol_q, ocol_d, row_div_q, row_div_d;
  logic [BW-1:0] cmod_q, cmod_d, rmod_q, rmod_d;
  logic [CW-1:0] out_cols_q, out_cols_d, out_rows_q, out_rows_d;

  logic [boxds_pkg::STEP_W-1:0] step_q, step_d;
  logic [DW-1:0] dq_q [NL];
  logic [DW-1:0] dq_d [NL];
  logic [DW-1:0] dq_n [NL];
  logic [BW-1:0] rm_q [NL];
  logic [BW-1:0] rm_d [NL];
  logic [BW-1:0] rm_n [NL];

  logic [DW-1:0] w_c, h_c, wm1, hm1, kept;
  logic [FW-1:0] f_c, fm1;
  logic          acc, cfg_wr, hit;

  assign w_c = (w_q == '0) ? DW'(1) : ((w_q > S_MAX) ? S_MAX : w_q);
  assign h_c = (h_q == '0) ? DW'(1) : ((h_q > S_MAX) ? S_MAX : h_q);
  assign f_c = (f_q < F_MIN) ? F_MIN : ((f_q > F_MAX) ? F_MAX : f_q);
  assign wm1 = w_c - DW'(1);
  assign hm1 = h_c - DW'(1);
  assign fm1 = f_c - FW'(1);

  assign kept = ({1'b0, out_cols_q} < KEEP_MAX) ? {1'b0, out_cols_q} : KEEP_MAX;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_RUN) && !full_i;
  assign acc         = in_valid_i && in_ready_o;
  assign recip_o     = boxds_pkg::recip(f_c);

  // Pixel lies in a whole, kept block
  assign hit = ({1'b0, ocol_q} < kept) && (row_div_q < out_rows_q);

  always_comb begin
    item_o.col   = ocol_q;
    item_o.fresh = (rib_q == '0) && (cib_q == '0);
    item_o.emit  = ({1'b0, cib_q} >= fm1) && ({1'b0, rib_q} >= fm1);
    item_o.fend  = (row_div_q == out_rows_q - CW'(1)) && ({1'b0, ocol_q} == kept - DW'(1));
    item_o.px[0] = chan_a_i;
    item_o.px[1] = tc_q ? chan_b_i : '0;
    item_o.px[2] = tc_q ? chan_c_i : '0;
  end

  assign push_o = acc && hit;

  // One restoring step per lane
  always_comb begin
    logic [FW-1:0] sh;
    logic          ge;
    for (int i = 0; i < NL; i++) begin
      sh      = {rm_q[i], dq_q[i][DW-1]};
      ge      = (sh >= f_c);
      rm_n[i] = ge ? BW'(sh - f_c) : sh[BW-1:0];
      dq_n[i] = {dq_q[i][DW-2:0], ge};
    end
  end

  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    h_d        = h_q;
    f_d        = f_q;
    tc_d       = tc_q;
    col_cnt_d  = col_cnt_q;
    row_cnt_d  = row_cnt_q;
    cib_d      = cib_q;
    rib_d      = rib_q;
    ocol_d     = ocol_q;
    row_div_d  = row_div_q;
    cmod_d     = cmod_q;
    rmod_d     = rmod_q;
    out_cols_d = out_cols_q;
    out_rows_d = out_rows_q;
    step_d     = step_q;
    dq_d       = dq_q;
    rm_d       = rm_q;

    case (state_q)
      ST_RUN: begin
        if (acc) begin
          if ({1'b0, col_cnt_q} >= wm1) begin
            col_cnt_d = '0;
            cib_d     = '0;
            ocol_d    = '0;
            cmod_d    = '0;
            if ({1'b0, row_cnt_q} >= hm1) begin
              row_cnt_d = '0;
              rib_d     = '0;
              row_div_d = '0;
              rmod_d    = '0;
            end else begin
              row_cnt_d = row_cnt_q + CW'(1);
              rib_d     = ({1'b0, rib_q} >= fm1) ? '0 : rib_q + BW'(1);
              if ({1'b0, rmod_q} >= fm1) begin
                rmod_d    = '0;
                row_div_d = row_div_q + CW'(1);
              end else begin
                rmod_d = rmod_q + BW'(1);
              end
            end
          end else begin
            col_cnt_d = col_cnt_q + CW'(1);
            cib_d     = ({1'b0, cib_q} >= fm1) ? '0 : cib_q + BW'(1);
            if ({1'b0, cmod_q} >= fm1) begin
              cmod_d = '0;
              ocol_d = ocol_q + CW'(1);
            end else begin
              cmod_d = cmod_q + BW'(1);
            end
          end
        end
      end
      ST_LOAD: begin
        dq_d[0] = w_c;
        dq_d[1] = h_c;
        dq_d[2] = {1'b0, col_cnt_q};
        dq_d[3] = {1'b0, row_cnt_q};
        for (int i = 0; i < NL; i++) rm_d[i] = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dq_d   = dq_n;
        rm_d   = rm_n;
        step_d = step_q + boxds_pkg::STEP_W'(1);
        if (step_q == boxds_pkg::STEP_W'(boxds_pkg::DIV_STEPS - 1)) begin
          out_cols_d = dq_n[0][CW-1:0];
          out_rows_d = dq_n[1][CW-1:0];
          ocol_d     = dq_n[2][CW-1:0];
          cmod_d     = rm_n[2];
          row_div_d  = dq_n[3][CW-1:0];
          rmod_d     = rm_n[3];
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase

    if (cfg_wr) begin
      case (cfg_index_i)
        boxds_pkg::CFG_SRC_WIDTH:  w_d  = cfg_data_i[DW-1:0];
        boxds_pkg::CFG_SRC_HEIGHT: h_d  = cfg_data_i[DW-1:0];
        boxds_pkg::CFG_FACTOR:     f_d  = cfg_data_i[FW-1:0];
        boxds_pkg::CFG_THREE_CHAN: tc_d = cfg_data_i[0];
        default: ;
      endcase
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      w_q        <= DW'(boxds_pkg::RST_SRC_WIDTH);
      h_q        <= DW'(boxds_pkg::RST_SRC_HEIGHT);
      f_q        <= FW'(boxds_pkg::RST_FACTOR);
      tc_q       <= 1'b0;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      cib_q      <= '0;
      rib_q      <= '0;
      ocol_q     <= '0;
      row_div_q  <= '0;
      cmod_q     <= '0;
      rmod_q     <= '0;
      out_cols_q <= CW'(boxds_pkg::RST_OUT_COLS);
      out_rows_q <= CW'(boxds_pkg::RST_OUT_ROWS);
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      w_q        <= w_d;
      h_q        <= h_d;
      f_q        <= f_d;
      tc_q       <= tc_d;
      col_cnt_q  <= col_cnt_d;
      row_cnt_q  <= row_cnt_d;
      cib_q      <= cib_d;
      rib_q      <= rib_d;
      ocol_q     <= ocol_d;
      row_div_q  <= row_div_d;
      cmod_q     <= cmod_d;
      rmod_q     <= rmod_d;
      out_cols_q <= out_cols_d;
      out_rows_q <= out_rows_d;
      step_q     <= step_d;
    end
  end

  // Divider lanes carry no control meaning
  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
    rm_q <= rm_d;
  end

endmodule

FILE: src/boxds_queue.sv
// ----------------------------------------------------------------------------
// boxds_queue
// Short FIFO of classified pixels between the front end and the back end.
// ----------------------------------------------------------------------------
module boxds_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  boxds_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output boxds_pkg::item_t item_o
);

  localparam int PW = boxds_pkg::QPTR_W;
  localparam int D  = boxds_pkg::QUEUE_DEPTH;

  boxds_pkg::item_t buf_q [D];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(D));
  assign valid_o = (cnt_q != '0);
  assign item_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: src/boxds_back.sv
// ----------------------------------------------------------------------------
// boxds_back
// Read-modify-write of the line store of partial sums, then division of the
// finished block sums by factor squared through a reciprocal multiply.
// ----------------------------------------------------------------------------
module boxds_back #(
  parameter int MAX_OUT_COLS = boxds_pkg::MAX_OUT_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  boxds_pkg::item_t              q_item_i,
  output logic                          q_pop_o,
  input  logic [boxds_pkg::REC_W-1:0]   recip_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [boxds_pkg::PIX_W-1:0]   avg_a_o,
  output logic [boxds_pkg::PIX_W-1:0]   avg_b_o,
  output logic [boxds_pkg::PIX_W-1:0]   avg_c_o,
  output logic                          frame_end_o
);

  localparam int AW = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int NC = boxds_pkg::NCHAN;
  localparam int SW = boxds_pkg::SUM_W;
  localparam int PX = boxds_pkg::PIX_W;
  localparam int RS = boxds_pkg::REC_SHIFT;
  localparam int PR = boxds_pkg::PROD_W;

  typedef logic [NC-1:0][SW-1:0] sums_t;

  sums_t mem_q [MAX_OUT_COLS];

  // stage 1: accumulate
  logic             s1_v_q;
  boxds_pkg::item_t s1_q;
  sums_t            rdata_q;
  logic             lw_hit_q;
  logic [AW-1:0]    lw_addr_q;
  sums_t            lw_sum_q;
  sums_t            base, sum;
  logic             s1_fire, s1_load;
  logic [AW-1:0]    s1_addr;

  // stage 2: finished sums
  logic  s2_v_q, s2_fend_q;
  sums_t s2_sum_q;
  logic  s2_rdy;

  // output register
  logic                  out_v_q, fend_q;
  logic [NC-1:0][PX-1:0] avg_q, avg_d;
  logic                  o_rdy;
  logic [PR-1:0]         prod [NC];

  assign s1_addr = s1_q.col[AW-1:0];
  assign o_rdy   = !out_v_q || out_ready_i;
  assign s2_rdy  = !s2_v_q || o_rdy;
  assign s1_fire = s1_v_q && (!s1_q.emit || s2_rdy);
  assign s1_load = q_valid_i && (!s1_v_q || s1_fire);
  assign q_pop_o = s1_load;

  // The write of the previous item lands on the same edge as this read
  assign base = (lw_hit_q && (lw_addr_q == s1_addr)) ? lw_sum_q : rdata_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sum[k] = s1_q.fresh ? SW'(s1_q.px[k]) : base[k] + SW'(s1_q.px[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      prod[k]  = PR'(s2_sum_q[k]) * PR'(recip_i);
      avg_d[k] = prod[k][RS+PX-1:RS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) mem_q[s1_addr] <= sum;
    if (s1_load) rdata_q <= mem_q[q_item_i.col[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      lw_hit_q <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q   <= 1'b1;
        lw_hit_q <= s1_fire;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire && s1_q.emit) begin
        s2_v_q <= 1'b1;
      end else if (o_rdy) begin
        s2_v_q <= 1'b0;
      end
      if (o_rdy) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q      <= q_item_i;
      lw_addr_q <= s1_addr;
      lw_sum_q  <= sum;
    end
    if (s1_fire && s1_q.emit) begin
      s2_sum_q  <= sum;
      s2_fend_q <= s1_q.fend;
    end
    if (o_rdy && s2_v_q) begin
      avg_q  <= avg_d;
      fend_q <= s2_fend_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign avg_a_o     = avg_q[0];
  assign avg_b_o     = avg_q[1];
  assign avg_c_o     = avg_q[2];
  assign frame_end_o = fend_q;

endmodule

FILE: src/box_average_downsampler.sv
// ----------------------------------------------------------------------------
// box_average_downsampler
// Box-filter decimator: averages factor x factor pixel blocks in raster order.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock while the queue has room and no divider
// pass runs, and gives at most one averaged pixel per clock; a pixel passes
// through a four-entry queue, a line store read-modify-write and a reciprocal
// multiply. Every register write starts a 13-step divider pass that
// re-derives the output geometry; input is held off until the pass after the
// last write ends. Writes are taken at any time and are meant to happen while
// no pixel is in flight. The line store holds MAX_OUT_COLS entries of three
// 16-bit sums and is not cleared.
module box_average_downsampler #(
  parameter int MAX_OUT_COLS = boxds_pkg::MAX_OUT_COLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [boxds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [boxds_pkg::PIX_W-1:0]      chan_a_i,
  input  logic [boxds_pkg::PIX_W-1:0]      chan_b_i,
  input  logic [boxds_pkg::PIX_W-1:0]      chan_c_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [boxds_pkg::PIX_W-1:0]      avg_a_o,
  output logic [boxds_pkg::PIX_W-1:0]      avg_b_o,
  output logic [boxds_pkg::PIX_W-1:0]      avg_c_o,
  output logic                             frame_end_o
);

  logic                       push, full, q_valid, q_pop;
  boxds_pkg::item_t           push_item, q_item;
  logic [boxds_pkg::REC_W-1:0] recip;

  boxds_front #(
    .MAX_OUT_COLS(MAX_OUT_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .chan_a_i    (chan_a_i),
    .chan_b_i    (chan_b_i),
    .chan_c_i    (chan_c_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item),
    .recip_o     (recip)
  );

  boxds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  boxds_back #(
    .MAX_OUT_COLS(MAX_OUT_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .recip_i     (recip),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .avg_a_o     (avg_a_o),
    .avg_b_o     (avg_b_o),
    .avg_c_o     (avg_c_o),
    .frame_end_o (frame_end_o)
  );

endmodule

FILE: src/boxds_checker.sv
// ----------------------------------------------------------------------------
// boxds_checker
// Port-level checks for the box average downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module boxds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [boxds_pkg::PIX_W-1:0] avg_a_o,
  input logic [boxds_pkg::PIX_W-1:0] avg_b_o,
  input logic [boxds_pkg::PIX_W-1:0] avg_c_o,
  input logic                        frame_end_o
);

  // stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(avg_a_o) &&
      $stable(avg_b_o) && $stable(avg_c_o) && $stable(frame_end_o))
    else $error("result changed while stalled");

  // geometry recompute holds off pixels after a register write
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("pixel request taken during geometry recompute");

  // nothing to show right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind box_average_downsampler boxds_checker u_boxds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .avg_a_o     (avg_a_o),
  .avg_b_o     (avg_b_o),
  .avg_c_o     (avg_c_o),
  .frame_end_o (frame_end_o)
);

FILE: verif/box_average_checker.sv
// ----------------------------------------------------------------------------
// box_average_checker
// Watches the register, pixel and average channels of the downsampler. Keeps
// its own copy of the registers, block counters and line store of channel
// sums, queues the average each block's last pixel should produce, and
// compares every accepted average field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module box_average_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [boxds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [boxds_pkg::PIX_W-1:0]      chan_a_i,
  input  logic [boxds_pkg::PIX_W-1:0]      chan_b_i,
  input  logic [boxds_pkg::PIX_W-1:0]      chan_c_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [boxds_pkg::PIX_W-1:0]      avg_a_i,
  input  logic [boxds_pkg::PIX_W-1:0]      avg_b_i,
  input  logic [boxds_pkg::PIX_W-1:0]      avg_c_i,
  input  logic                             frame_end_i,
  output int                               mismatch_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import boxds_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] avg_a;
    logic [PIX_W-1:0] avg_b;
    logic [PIX_W-1:0] avg_c;
    logic             fend;
  } avg_pixel_t;

  logic [SUM_W-1:0] col_sums [MAX_OUT_COLS_DEF][NCHAN];
  logic [DIM_W-1:0] reg_width;
  logic [DIM_W-1:0] reg_height;
  logic [FAC_W-1:0] reg_factor;
  logic             reg_three;
  int unsigned      col_pos, row_pos, col_in_blk, row_in_blk;
  avg_pixel_t       expected_avgs[$];
  avg_pixel_t       oldest;

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic int unsigned clamp(input int unsigned v, lo, hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void accumulate_pixel(input logic [PIX_W-1:0] pa, pb, pc);
    int unsigned      w, h, f, out_cols, out_rows, kept_cols, ocol, area;
    logic [PIX_W-1:0] px [NCHAN];
    avg_pixel_t       avg;
    int               k;
    w = clamp(reg_width, 1, SRC_MAX);
    h = clamp(reg_height, 1, SRC_MAX);
    f = clamp(reg_factor, MIN_FACTOR, MAX_FACTOR);
    out_cols = w / f;
    out_rows = h / f;
    kept_cols = (out_cols < MAX_OUT_COLS_DEF) ? out_cols : MAX_OUT_COLS_DEF;
    ocol = col_pos / f;
    px[0] = pa;
    px[1] = reg_three ? pb : '0;
    px[2] = reg_three ? pc : '0;

    // partial columns and rows at the right and bottom edges are dropped
    if (col_pos < out_cols * f && row_pos < out_rows * f && ocol < kept_cols) begin
      for (k = 0; k < NCHAN; k++)
        col_sums[ocol][k] = ((row_in_blk == 0 && col_in_blk == 0) ? '0 : col_sums[ocol][k])
                            + px[k];
      if (col_in_blk >= f - 1 && row_in_blk >= f - 1) begin
        area = f * f;
        avg.avg_a = PIX_W'(col_sums[ocol][0] / area);
        avg.avg_b = PIX_W'(col_sums[ocol][1] / area);
        avg.avg_c = PIX_W'(col_sums[ocol][2] / area);
        avg.fend  = (row_pos / f == out_rows - 1) && (ocol == kept_cols - 1);
        expected_avgs.push_back(avg);
      end
    end

    if (col_pos >= w - 1) begin
      col_pos = 0;
      col_in_blk = 0;
      if (row_pos >= h - 1) begin
        row_pos = 0;
        row_in_blk = 0;
      end else begin
        row_pos++;
        row_in_blk = (row_in_blk >= f - 1) ? 0 : row_in_blk + 1;
      end
    end else begin
      col_pos++;
      col_in_blk = (col_in_blk >= f - 1) ? 0 : col_in_blk + 1;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reg_width  = RST_SRC_WIDTH;
      reg_height = RST_SRC_HEIGHT;
      reg_factor = RST_FACTOR;
      reg_three  = 1'b0;
      col_pos    = 0;
      row_pos    = 0;
      col_in_blk = 0;
      row_in_blk = 0;
      expected_avgs.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  reg_width  = cfg_data_i;
          CFG_SRC_HEIGHT: reg_height = cfg_data_i;
          CFG_FACTOR:     reg_factor = cfg_data_i[FAC_W-1:0];
          CFG_THREE_CHAN: reg_three  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) accumulate_pixel(chan_a_i, chan_b_i, chan_c_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_avgs.size() == 0) begin
          report_mismatch($sformatf("unexpected average %0d/%0d/%0d frame_end %0b",
                                    avg_a_i, avg_b_i, avg_c_i, frame_end_i));
        end else begin
          oldest = expected_avgs.pop_front();
          if (avg_a_i !== oldest.avg_a)
            report_mismatch($sformatf("avg_a got %0d exp %0d", avg_a_i, oldest.avg_a));
          if (avg_b_i !== oldest.avg_b)
            report_mismatch($sformatf("avg_b got %0d exp %0d", avg_b_i, oldest.avg_b));
          if (avg_c_i !== oldest.avg_c)
            report_mismatch($sformatf("avg_c got %0d exp %0d", avg_c_i, oldest.avg_c));
          if (frame_end_i !== oldest.fend)
            report_mismatch($sformatf("frame_end got %0b exp %0b", frame_end_i, oldest.fend));
        end
      end
    end
    pending_o = expected_avgs.size();
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the box-average downsampler with register settings and pixel frames:
// reset geometry, short directed frames for the edge cases, random frames
// under varying back-pressure, then the largest block. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import boxds_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_PIXELS  = 900;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      chan_a    = '0;
  logic [PIX_W-1:0]      chan_b    = '0;
  logic [PIX_W-1:0]      chan_c    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      avg_a, avg_b, avg_c;
  logic                  frame_end;

  int mismatches, pending;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int tx_calm      = 0;
  int rx_calm      = 0;
  int pixels_sent  = 0;
  int stall_cycles = 0;

  box_average_downsampler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .chan_a_i    (chan_a),
    .chan_b_i    (chan_b),
    .chan_c_i    (chan_c),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .avg_a_o     (avg_a),
    .avg_b_o     (avg_b),
    .avg_c_o     (avg_c),
    .frame_end_o (frame_end)
  );

  box_average_checker avg_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .chan_a_i         (chan_a),
    .chan_b_i         (chan_b),
    .chan_c_i         (chan_c),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .avg_a_i          (avg_a),
    .avg_b_i          (avg_b),
    .avg_c_i          (avg_c),
    .frame_end_i      (frame_end),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver back-pressure, with occasional stall-free stretches
  always @(negedge clk) begin
    if (rx_calm > 0) begin
      rx_calm--;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      rx_calm = $urandom_range(10, 40);
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("box_average_downsampler test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic set_idling(input int tx_pct, rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // called and returns at a falling edge; valid stays high for a back-to-back request
  task automatic send_pixel(input logic [PIX_W-1:0] a, b, c);
    if (tx_calm > 0) begin
      tx_calm--;
    end else if ($urandom_range(0, 99) < 2) begin
      tx_calm = $urandom_range(10, 40);
    end else begin
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    chan_a   <= a;
    chan_b   <= b;
    chan_c   <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] pixel_byte(input bit saturate);
    if (saturate && $urandom_range(0, 9) != 0) return '1;
    return PIX_W'($urandom);
  endfunction

  task automatic send_frame(input int w, h, input bit saturate);
    int n;
    for (n = 0; n < w * h; n++)
      send_pixel(pixel_byte(saturate), pixel_byte(saturate), pixel_byte(saturate));
  endtask

  task automatic send_fill(input int count, input logic [PIX_W-1:0] a, b, c);
    repeat (count) send_pixel(a, b, c);
  endtask

  // wait until every average is out and pixels that give none have drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int w, h, f, three);
    settle();
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_SRC_HEIGHT, h);
    write_reg(CFG_FACTOR, f);
    write_reg(CFG_THREE_CHAN, three);
  endtask

  initial begin
    int start, roll, f, w, h, span;
    set_idling(35, 58);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: 64 wide, factor 2, gray; two rows give one row of averages
    send_frame(RST_SRC_WIDTH, 2, 1'b0);
    // shrinking the height makes the row in progress the last one of the frame
    settle();
    write_reg(CFG_SRC_HEIGHT, 2);
    send_frame(RST_SRC_WIDTH, 1, 1'b0);

    // full-scale and zero blocks in color
    configure(2, 2, 2, 1);
    send_fill(4, '1, '1, '1);
    send_fill(4, '0, '0, '0);
    // odd size leaves a dropped column and row; gray ignores b and c
    configure(3, 3, 2, 0);
    send_frame(3, 3, 1'b0);
    // factor taller than the image: pixels consumed, no average
    configure(2, 1, 2, 1);
    send_frame(2, 1, 1'b0);
    // height shrinks mid-frame: the next row beyond the new limit ends the frame
    configure(2, 4, 2, 1);
    send_frame(2, 2, 1'b0);
    settle();
    write_reg(CFG_SRC_HEIGHT, 2);
    send_frame(2, 1, 1'b0);

    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (pixels_sent - start < RANDOM_PIXELS / 3) set_idling(35, 58);
      else if (pixels_sent - start < 2 * RANDOM_PIXELS / 3) set_idling(58, 35);
      else set_idling(0, 0);
      roll = $urandom_range(0, 99);
      if (roll < 15) f = $urandom_range(12, MAX_FACTOR);
      else if (roll < 25) f = MIN_FACTOR;
      else f = $urandom_range(MIN_FACTOR, 11);
      // keep frames small: a few blocks across and down
      span = (24 / f > 1) ? 24 / f : 1;
      w = f * $urandom_range(1, span) + $urandom_range(0, f - 1);
      if ($urandom_range(0, 9) == 0) h = $urandom_range(1, f - 1);
      else h = f * $urandom_range(1, span) + $urandom_range(0, f - 1);
      configure(w, h, f, $urandom_range(0, 1));
      repeat ($urandom_range(1, 2)) send_frame(w, h, $urandom_range(0, 9) == 0);
    end

    // largest block at full scale
    set_idling(0, 0);
    configure(MAX_FACTOR, MAX_FACTOR, MAX_FACTOR, 1);
    send_fill(MAX_FACTOR * MAX_FACTOR, '1, '1, '1);
    settle();

    if (mismatches == 0) $display("box_average_downsampler test passed");
    else $display("box_average_downsampler test failed");
    $finish;
  end

endmodule
